[hdl/fqs_pkg.sv]
`default_nettype none
package fqs_pkg;

  // storage depth and derived widths
  localparam int MAX_CUSTOMERS = 4096;
  localparam int IDX_W = (MAX_CUSTOMERS > 2) ? $clog2(MAX_CUSTOMERS) : 1;
  localparam int CNT_W = $clog2(MAX_CUSTOMERS + 1);
  localparam int AMT_W = 32;
  localparam int CUST_W = 13;

  // operation codes
  typedef enum logic [1:0] {
    OP_ARRIVE  = 2'd0,
    OP_OLDEST  = 2'd1,
    OP_RICHEST = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // status codes
  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // control sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_OUT
  } state_t;

  // per-cycle control shared by every cell of the ring
  typedef struct packed {
    logic             shift;
    logic             load;
    logic             set_mark;
    logic [IDX_W-1:0] idx;
    logic [AMT_W-1:0] amount;
  } ring_ctl_t;

endpackage
`default_nettype wire

[hdl/fifo_or_richest_service_queue_core.sv]
`default_nettype none
// Dual-order service queue. Arrival (operation 0) stores the amount and
// returns the next customer number, from 1; serve-oldest (1) and
// serve-richest (2) return the earliest unserved customer or the unserved
// one with the largest amount, ties going to the earliest. Entries sit in a
// ring of MAX_CUSTOMERS cells; a serve turns the ring once past a compare
// unit at cell 0 and then marks the chosen cell, while arrivals, empty
// serves and code 3 skip the scan and go straight to the result. One item is
// in work at a time; the result waits in an output register while the
// input side stays open for the next transfer.
module fifo_or_richest_service_queue_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  operation,
  input  wire logic [fqs_pkg::AMT_W-1:0]   amount,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [1:0]                  status,
  output logic      [fqs_pkg::CUST_W-1:0]  customer
);

  fqs_pkg::state_t  state, state_next;
  fqs_pkg::ring_ctl_t ctl;

  logic [fqs_pkg::CNT_W-1:0]  arrival_count;
  logic [fqs_pkg::CNT_W-1:0]  waiting_count;
  logic [fqs_pkg::IDX_W-1:0]  scan_k;
  logic                       scan_richest;
  logic [fqs_pkg::IDX_W-1:0]  best;
  logic [fqs_pkg::AMT_W-1:0]  best_amt;
  logic                       found;
  logic [1:0]                 res_status;
  logic [fqs_pkg::CUST_W-1:0] res_cust;
  logic [fqs_pkg::AMT_W-1:0]  head_amount;
  logic                       head_mark;

  logic accept, is_arrive, is_serve, full, scan_last, live, take, out_free;

  assign accept    = in_valid && !in_stall;
  assign is_arrive = (operation == fqs_pkg::OP_ARRIVE);
  assign is_serve  = (operation == fqs_pkg::OP_OLDEST || operation == fqs_pkg::OP_RICHEST)
                     && (waiting_count != '0);
  assign full      = (arrival_count == fqs_pkg::CNT_W'(fqs_pkg::MAX_CUSTOMERS));
  assign scan_last = (scan_k == fqs_pkg::IDX_W'(fqs_pkg::MAX_CUSTOMERS - 1));
  assign live      = (fqs_pkg::CNT_W'(scan_k) < arrival_count) && !head_mark;
  assign take      = live && (!found || (scan_richest && head_amount > best_amt));
  assign out_free  = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fqs_pkg::S_IDLE: if (accept) state_next = is_serve ? fqs_pkg::S_SCAN : fqs_pkg::S_OUT;
      fqs_pkg::S_SCAN: if (scan_last) state_next = fqs_pkg::S_MARK;
      fqs_pkg::S_MARK: state_next = fqs_pkg::S_OUT;
      fqs_pkg::S_OUT:  if (out_free) state_next = fqs_pkg::S_IDLE;
      default:         state_next = fqs_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall     = 1'b1;
    ctl.shift    = 1'b0;
    ctl.load     = 1'b0;
    ctl.set_mark = 1'b0;
    ctl.idx      = best;
    ctl.amount   = amount;
    case (state)
      fqs_pkg::S_IDLE: begin
        in_stall = 1'b0;
        ctl.load = accept && is_arrive && !full;
        ctl.idx  = arrival_count[fqs_pkg::IDX_W-1:0];
      end
      fqs_pkg::S_SCAN: ctl.shift = 1'b1;
      fqs_pkg::S_MARK: ctl.set_mark = found;
      fqs_pkg::S_OUT:  ;
      default:         ;
    endcase
  end

  fqs_ring u_ring (
    .clk        (clk),
    .ctl        (ctl),
    .head_amount(head_amount),
    .head_mark  (head_mark)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fqs_pkg::S_IDLE;
      arrival_count <= '0;
      waiting_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load) begin
        arrival_count <= arrival_count + fqs_pkg::CNT_W'(1);
        waiting_count <= waiting_count + fqs_pkg::CNT_W'(1);
      end
      if (ctl.set_mark) waiting_count <= waiting_count - fqs_pkg::CNT_W'(1);
      if (state == fqs_pkg::S_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // scan and result datapath
  always_ff @(posedge clk) begin
    if (state == fqs_pkg::S_IDLE && accept) begin
      scan_k       <= '0;
      found        <= 1'b0;
      scan_richest <= (operation == fqs_pkg::OP_RICHEST);
      res_cust     <= '0;
      if (is_arrive && full) begin
        res_status <= fqs_pkg::ST_FULL;
      end else if (is_arrive) begin
        res_status <= fqs_pkg::ST_ACCEPTED;
        res_cust   <= fqs_pkg::CUST_W'(arrival_count + fqs_pkg::CNT_W'(1));
      end else begin
        res_status <= fqs_pkg::ST_EMPTY;
      end
    end
    if (state == fqs_pkg::S_SCAN) begin
      scan_k <= scan_k + fqs_pkg::IDX_W'(1);
      if (take) begin
        found    <= 1'b1;
        best     <= scan_k;
        best_amt <= head_amount;
      end
    end
    if (state == fqs_pkg::S_MARK && found) begin
      res_status <= fqs_pkg::ST_SERVED;
      res_cust   <= fqs_pkg::CUST_W'(fqs_pkg::CNT_W'(best) + fqs_pkg::CNT_W'(1));
    end
    if (state == fqs_pkg::S_OUT && out_free) begin
      status   <= res_status;
      customer <= res_cust;
    end
  end

`ifndef NO_ASSERTIONS
  a_wait_le_arr: assert property (@(posedge clk) disable iff (rst)
    waiting_count <= arrival_count) else $error("waiting exceeds arrivals");
  a_arr_cap: assert property (@(posedge clk) disable iff (rst)
    arrival_count <= fqs_pkg::CNT_W'(fqs_pkg::MAX_CUSTOMERS)) else $error("arrivals past capacity");
  a_scan_step: assert property (@(posedge clk) disable iff (rst)
    (state == fqs_pkg::S_SCAN && !scan_last) |=> (state == fqs_pkg::S_SCAN
      && scan_k == $past(scan_k) + fqs_pkg::IDX_W'(1))) else $error("scan stalled");
  a_serve_found: assert property (@(posedge clk) disable iff (rst)
    (state == fqs_pkg::S_MARK) |-> found) else $error("serve found nobody");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != fqs_pkg::S_IDLE) |-> in_stall) else $error("input open while busy");
`endif

endmodule
`default_nettype wire

[hdl/fqs_cell.sv]
`default_nettype none
// One entry of the ring: amount and served mark.
module fqs_cell (
  input  wire logic                     clk,
  input  wire logic                     shift,
  input  wire logic                     load,
  input  wire logic                     set_mark,
  input  wire logic [fqs_pkg::AMT_W-1:0] load_amount,
  input  wire logic [fqs_pkg::AMT_W-1:0] in_amount,
  input  wire logic                     in_mark,
  output logic      [fqs_pkg::AMT_W-1:0] amount,
  output logic                          mark
);

  // load on arrival, mark on serve, otherwise pass along the ring
  always_ff @(posedge clk) begin
    if (load) begin
      amount <= load_amount;
      mark   <= 1'b0;
    end else if (set_mark) begin
      mark <= 1'b1;
    end else if (shift) begin
      amount <= in_amount;
      mark   <= in_mark;
    end
  end

endmodule
`default_nettype wire

[hdl/fqs_ring.sv]
`default_nettype none
// Ring of cells. A shift moves every entry one place toward cell 0, and
// cell 0 wraps to the far end; a full turn restores the original order.
module fqs_ring (
  input  wire logic                      clk,
  input  wire fqs_pkg::ring_ctl_t        ctl,
  output logic      [fqs_pkg::AMT_W-1:0] head_amount,
  output logic                           head_mark
);

  logic [fqs_pkg::AMT_W-1:0] amt [fqs_pkg::MAX_CUSTOMERS];
  logic                      mrk [fqs_pkg::MAX_CUSTOMERS];

  for (genvar i = 0; i < fqs_pkg::MAX_CUSTOMERS; i++) begin : g_cell
    localparam int NXT = (i + 1) % fqs_pkg::MAX_CUSTOMERS;
    logic hit;
    assign hit = (ctl.idx == fqs_pkg::IDX_W'(i));
    fqs_cell u_cell (
      .clk        (clk),
      .shift      (ctl.shift),
      .load       (ctl.load && hit),
      .set_mark   (ctl.set_mark && hit),
      .load_amount(ctl.amount),
      .in_amount  (amt[NXT]),
      .in_mark    (mrk[NXT]),
      .amount     (amt[i]),
      .mark       (mrk[i])
    );
  end

  assign head_amount = amt[0];
  assign head_mark   = mrk[0];

endmodule
`default_nettype wire

[tb/fifo_or_richest_service_queue_core_tb.sv]
`default_nettype none
module fifo_or_richest_service_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]                op;
    logic [fqs_pkg::AMT_W-1:0] amt;
  } request_t;

  typedef struct packed {
    logic [1:0]                 st;
    logic [fqs_pkg::CUST_W-1:0] cust;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = fqs_pkg::OP_NONE;
  logic [fqs_pkg::AMT_W-1:0] amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [fqs_pkg::CUST_W-1:0] customer;

  fifo_or_richest_service_queue_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .amount(amount),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .customer(customer)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // queue model state
  logic [fqs_pkg::AMT_W-1:0] amt_mem [fqs_pkg::MAX_CUSTOMERS];
  bit served_mem [fqs_pkg::MAX_CUSTOMERS];
  int unsigned arrivals, head, waiting;

  request_t pending_reqs[$];
  reply_t   expected_replies[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 0;

  function automatic int unsigned rand_gap();
    if ($urandom_range(3) == 0) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 5);
    return $urandom_range(2);
  endfunction

  // compute the reply for one transfer and update the model
  function automatic reply_t serve_model(request_t r);
    reply_t rp;
    int unsigned best;
    logic [fqs_pkg::AMT_W-1:0] best_amt;
    rp.cust = '0;
    if (r.op == fqs_pkg::OP_ARRIVE) begin
      if (arrivals >= fqs_pkg::MAX_CUSTOMERS) begin
        rp.st = fqs_pkg::ST_FULL;
        return rp;
      end
      amt_mem[arrivals] = r.amt;
      served_mem[arrivals] = 0;
      arrivals++;
      waiting++;
      rp.st = fqs_pkg::ST_ACCEPTED;
      rp.cust = arrivals[fqs_pkg::CUST_W-1:0];
      return rp;
    end
    rp.st = fqs_pkg::ST_EMPTY;
    if (r.op == fqs_pkg::OP_NONE || waiting == 0) return rp;
    if (r.op == fqs_pkg::OP_OLDEST) begin
      while (head < arrivals && served_mem[head]) head++;
      best = head;
    end else begin
      best = arrivals;
      best_amt = '0;
      for (int k = 0; k < arrivals; k++) begin
        if (!served_mem[k] && (best == arrivals || amt_mem[k] > best_amt)) begin
          best = k;
          best_amt = amt_mem[k];
        end
      end
    end
    if (best >= arrivals) return rp;
    served_mem[best] = 1;
    waiting--;
    rp.st = fqs_pkg::ST_SERVED;
    rp.cust = fqs_pkg::CUST_W'(best + 1);
    return rp;
  endfunction

  // driver: one transfer at a time from the pending queue
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_replies.push_back(serve_model('{operation, amount}));
        send_gap = rand_gap();
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          request_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          operation <= r.op;
          amount <= r.amt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  int unsigned stall_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected result status=%0d customer=%0d", status, customer);
          errors++;
        end else begin
          reply_t e;
          e = expected_replies.pop_front();
          if (status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, status);
            errors++;
          end
          if (customer !== e.cust) begin
            $error("customer expected %0d actual %0d", e.cust, customer);
            errors++;
          end
        end
      end
      // stall bursts of random length on the result side
      if (stall_gap > 0) begin
        stall_gap--;
        out_stall <= 1'b1;
      end else begin
        stall_gap = stim_done ? 0 : rand_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [fqs_pkg::AMT_W-1:0] rand_amt();
    case ($urandom_range(3))
      0: return $urandom_range(7);
      1: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic add(logic [1:0] op, logic [fqs_pkg::AMT_W-1:0] a);
    pending_reqs.push_back('{op, a});
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // directed: empty serves, unused code, extremes, ties
    add(fqs_pkg::OP_OLDEST, 32'h0);
    add(fqs_pkg::OP_RICHEST, 32'hFFFF_FFFF);
    add(fqs_pkg::OP_NONE, 32'h5555_5555);
    add(fqs_pkg::OP_ARRIVE, 32'h0);
    add(fqs_pkg::OP_ARRIVE, 32'hFFFF_FFFF);
    add(fqs_pkg::OP_ARRIVE, 32'hFFFF_FFFF);
    add(fqs_pkg::OP_ARRIVE, 32'hAAAA_AAAA);
    add(fqs_pkg::OP_ARRIVE, 32'h0);
    add(fqs_pkg::OP_RICHEST, 32'h0);
    add(fqs_pkg::OP_RICHEST, 32'h0);
    add(fqs_pkg::OP_OLDEST, 32'h0);
    add(fqs_pkg::OP_OLDEST, 32'h0);
    add(fqs_pkg::OP_NONE, 32'h0);
    add(fqs_pkg::OP_RICHEST, 32'h0);
    add(fqs_pkg::OP_OLDEST, 32'h0);
    add(fqs_pkg::OP_RICHEST, 32'h0);
    // sender holds off until all results are back
    wait_drained();
    // random mix, arrivals favored so serves find work
    for (int i = 0; i < 120; i++) begin
      int unsigned p;
      p = $urandom_range(99);
      if (p < 45) add(fqs_pkg::OP_ARRIVE, rand_amt());
      else if (p < 70) add(fqs_pkg::OP_OLDEST, $urandom);
      else if (p < 95) add(fqs_pkg::OP_RICHEST, $urandom);
      else add(fqs_pkg::OP_NONE, $urandom);
      if (i == 60) begin
        wait_drained();
      end
    end
    wait_drained();
    add(fqs_pkg::OP_RICHEST, 32'h0);
    add(fqs_pkg::OP_ARRIVE, 32'h1);
    add(fqs_pkg::OP_OLDEST, 32'h0);
    stim_done = 1;
    wait_drained();
    repeat (fqs_pkg::MAX_CUSTOMERS + 20) @(posedge clk);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
hdl/fqs_pkg.sv
hdl/fqs_cell.sv
hdl/fqs_ring.sv
hdl/fifo_or_richest_service_queue_core.sv
tb/fifo_or_richest_service_queue_core_tb.sv
